// ===== rtl/core/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// Spatial grid binner package
// Field widths, operation and status codes, register indexes and reset
// values shared by the binner, its channels and its checker.
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int OP_W    = 2;
    localparam int ID_W    = 10;
    localparam int POS_W   = 24;
    localparam int QCELL_W = 10;
    localparam int QSLOT_W = 4;
    localparam int CELL_W  = 10;
    localparam int SLOTO_W = 4;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;

    localparam int HALF_W  = 12;
    localparam int EDGE_W  = 13;
    localparam int GRID_W  = 11;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 13;

    localparam int MAX_CELLS_DEF      = 1024;
    localparam int SLOTS_PER_CELL_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 8;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_HALF_WIDTH   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_HALF_HEIGHT  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CELL_EDGE    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_GRID_COLUMNS = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GRID_ROWS    = 3'd4;

    localparam logic [HALF_W-1:0] HALF_WIDTH_RST   = 12'd320;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST  = 12'd240;
    localparam logic [EDGE_W-1:0] CELL_EDGE_RST    = 13'd32;
    localparam logic [GRID_W-1:0] GRID_COLUMNS_RST = 11'd20;
    localparam logic [GRID_W-1:0] GRID_ROWS_RST    = 11'd15;

    typedef struct packed {
        logic              start;
        logic [EDGE_W-1:0] divisor;
    } sgb_div_req_t;

endpackage

// ===== rtl/core/sgb_if.sv =====
// ----------------------------------------------------------------------------
// Spatial grid binner channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface sgb_item_if
    import sgb_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [ID_W-1:0]           particle_id;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic [QCELL_W-1:0]        query_cell;
    logic [QSLOT_W-1:0]        query_slot;

    modport source (
        output valid, operation, particle_id, pos_x, pos_y, query_cell, query_slot,
        input  ready
    );
    modport sink (
        input  valid, operation, particle_id, pos_x, pos_y, query_cell, query_slot,
        output ready
    );
endinterface

interface sgb_result_if
    import sgb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_index;
    logic [SLOTO_W-1:0]   slot_index;
    logic [ID_W-1:0]      stored_id;
    logic [FILL_W-1:0]    cell_fill;
    logic [STAT_W-1:0]    status;

    modport source (
        output valid, cell_index, slot_index, stored_id, cell_fill, status,
        input  ready
    );
    modport sink (
        input  valid, cell_index, slot_index, stored_id, cell_fill, status,
        output ready
    );
endinterface

interface sgb_cfg_if
    import sgb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/core/spatial_grid_binner_core.sv =====
// ----------------------------------------------------------------------------
// Spatial grid binner core
// A place request computes its cell on the shared divider, one quotient bit
// per cycle for each axis in turn, with a dividend of D bits (16 with 8
// fraction bits). A clear writes one count per cycle over all MAX_CELLS cells.
// One request at a time; the next is taken while the result waits.
// After reset a clearing pass over all MAX_CELLS counts runs before the first
// request.
// ----------------------------------------------------------------------------
module spatial_grid_binner_core
    import sgb_pkg::*;
#(
    parameter int MAX_CELLS      = MAX_CELLS_DEF,
    parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    sgb_item_if.sink     item,
    sgb_result_if.source result,
    sgb_cfg_if.sink      cfg
);

    localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SLOT_W    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int CNT_W     = $clog2(SLOTS_PER_CELL + 1);
    localparam int BKT_DEPTH = MAX_CELLS * SLOTS_PER_CELL;
    localparam int BKT_AW    = (BKT_DEPTH > 1) ? $clog2(BKT_DEPTH) : 1;
    localparam int SUM_W     = ((POS_W > HALF_W + 1 + FRACTION_BITS) ?
                                POS_W : HALF_W + 1 + FRACTION_BITS) + 1;
    localparam int DIV_W     = SUM_W - 1 - FRACTION_BITS;
    localparam int CMP_W     = (DIV_W > GRID_W) ? DIV_W : GRID_W;
    localparam int PROD_W    = 2 * GRID_W;
    localparam int IDX_W     = PROD_W + 1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_AXIS_X,
        S_DIV_X,
        S_AXIS_Y,
        S_DIV_Y,
        S_MUL,
        S_INDEX,
        S_CNT_RD,
        S_PLACE,
        S_RCHECK,
        S_READ,
        S_RESULT
    } state_t;

    state_t                 state_reg, state_next;

    logic [HALF_W-1:0]      half_w_reg, half_w_next;
    logic [HALF_W-1:0]      half_h_reg, half_h_next;
    logic [EDGE_W-1:0]      edge_reg, edge_next;
    logic [GRID_W-1:0]      cols_reg, cols_next;
    logic [GRID_W-1:0]      rows_reg, rows_next;

    logic [OP_W-1:0]        op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic signed [POS_W-1:0] px_reg, px_next;
    logic signed [POS_W-1:0] py_reg, py_next;
    logic [QCELL_W-1:0]     qc_reg, qc_next;
    logic [QSLOT_W-1:0]     qs_reg, qs_next;

    logic [GRID_W-1:0]      cx_reg, cx_next;
    logic [GRID_W-1:0]      cy_reg, cy_next;
    logic [PROD_W-1:0]      mul_reg, mul_next;
    logic [CELL_AW-1:0]     cell_reg, cell_next;
    logic [CELL_AW-1:0]     sweep_reg, sweep_next;

    logic [CELL_W-1:0]      res_cell_reg, res_cell_next;
    logic [SLOTO_W-1:0]     res_slot_reg, res_slot_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic [FILL_W-1:0]      res_fill_reg, res_fill_next;
    logic [STAT_W-1:0]      res_stat_reg, res_stat_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]      out_cell_reg, out_cell_next;
    logic [SLOTO_W-1:0]     out_slot_reg, out_slot_next;
    logic [ID_W-1:0]        out_id_reg, out_id_next;
    logic [FILL_W-1:0]      out_fill_reg, out_fill_next;
    logic [STAT_W-1:0]      out_stat_reg, out_stat_next;

    logic [CNT_W-1:0]       cnt_mem [MAX_CELLS];
    logic [CNT_W-1:0]       cnt_rd_reg;
    logic                   cnt_we;
    logic [CELL_AW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]       cnt_wdata;
    logic [CNT_W-1:0]       cnt_inc;

    logic [ID_W-1:0]        bkt_mem [BKT_DEPTH];
    logic [ID_W-1:0]        bkt_rd_reg;
    logic                   bkt_we;
    logic [SLOT_W-1:0]      slot_sel;
    logic [BKT_AW-1:0]      bkt_addr;

    logic                   axis_y;
    logic signed [POS_W-1:0] pos_sel;
    logic [HALF_W-1:0]      half_sel;
    logic [SUM_W-1:0]       axis_sum;
    logic [GRID_W-1:0]      limit_sel;
    logic                   q_outside;
    logic [GRID_W-1:0]      mul_a;
    logic [GRID_W-1:0]      mul_b;
    logic [IDX_W-1:0]       idx_sum;

    sgb_div_req_t           div_req;
    logic                   div_done;
    logic [DIV_W-1:0]       div_q;

    sgb_divider #(
        .DIVIDEND_W (DIV_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (axis_sum[SUM_W-2:FRACTION_BITS]),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        axis_y    = (state_reg == S_AXIS_Y);
        pos_sel   = axis_y ? py_reg : px_reg;
        half_sel  = axis_y ? half_h_reg : half_w_reg;
        axis_sum  = SUM_W'(pos_sel) + (SUM_W'(half_sel) << FRACTION_BITS);
        limit_sel = (state_reg == S_DIV_Y) ? rows_reg : cols_reg;
        q_outside = CMP_W'(div_q) >= CMP_W'(limit_sel);
        mul_a     = (op_reg == OP_PLACE) ? cy_reg : cols_reg;
        mul_b     = (op_reg == OP_PLACE) ? cols_reg : rows_reg;
        idx_sum   = IDX_W'(mul_reg) + IDX_W'(cx_reg);
        cnt_inc   = cnt_rd_reg + 1'b1;
        slot_sel  = (op_reg == OP_READ) ? SLOT_W'(qs_reg) : SLOT_W'(cnt_rd_reg);
        bkt_addr  = BKT_AW'(32'(cell_reg) * 32'(SLOTS_PER_CELL) + 32'(slot_sel));

        div_req.start   = 1'b0;
        div_req.divisor = (edge_reg == '0) ? EDGE_W'(1) : edge_reg;

        cnt_we    = 1'b0;
        cnt_waddr = sweep_reg;
        cnt_wdata = '0;
        bkt_we    = 1'b0;

        state_next  = state_reg;
        half_w_next = half_w_reg;
        half_h_next = half_h_reg;
        edge_next   = edge_reg;
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        qc_next     = qc_reg;
        qs_next     = qs_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        mul_next    = mul_reg;
        cell_next   = cell_reg;
        sweep_next  = sweep_reg;

        res_cell_next = res_cell_reg;
        res_slot_next = res_slot_reg;
        res_id_next   = res_id_reg;
        res_fill_next = res_fill_reg;
        res_stat_next = res_stat_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_cell_next  = out_cell_reg;
        out_slot_next  = out_slot_reg;
        out_id_next    = out_id_reg;
        out_fill_next  = out_fill_reg;
        out_stat_next  = out_stat_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HALF_WIDTH:   half_w_next = cfg.data[HALF_W-1:0];
                CFG_HALF_HEIGHT:  half_h_next = cfg.data[HALF_W-1:0];
                CFG_CELL_EDGE:    edge_next   = cfg.data[EDGE_W-1:0];
                CFG_GRID_COLUMNS: cols_next   = cfg.data[GRID_W-1:0];
                CFG_GRID_ROWS:    rows_next   = cfg.data[GRID_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cnt_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == CELL_AW'(MAX_CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_RESULT;
                end
            end

            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next       = item.operation;
                    id_next       = item.particle_id;
                    px_next       = item.pos_x;
                    py_next       = item.pos_y;
                    qc_next       = item.query_cell;
                    qs_next       = item.query_slot;
                    res_cell_next = '0;
                    res_slot_next = '0;
                    res_id_next   = '0;
                    res_fill_next = '0;
                    res_stat_next = ST_OK;
                    unique case (item.operation)
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_PLACE: state_next = S_AXIS_X;
                        OP_READ:  state_next = S_MUL;
                        default:  state_next = S_RESULT;
                    endcase
                end
            end

            S_AXIS_X, S_AXIS_Y:
            begin
                if (axis_sum[SUM_W-1])
                begin
                    res_stat_next = ST_OUTSIDE;
                    state_next    = S_RESULT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = axis_y ? S_DIV_Y : S_DIV_X;
                end
            end

            S_DIV_X, S_DIV_Y:
            begin
                if (div_done)
                begin
                    if (q_outside)
                    begin
                        res_stat_next = ST_OUTSIDE;
                        state_next    = S_RESULT;
                    end
                    else if (state_reg == S_DIV_X)
                    begin
                        cx_next    = GRID_W'(div_q);
                        state_next = S_AXIS_Y;
                    end
                    else
                    begin
                        cy_next    = GRID_W'(div_q);
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                mul_next   = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = (op_reg == OP_PLACE) ? S_INDEX : S_RCHECK;
            end

            S_INDEX:
            begin
                if (32'(idx_sum) >= 32'(MAX_CELLS))
                begin
                    res_stat_next = ST_OUTSIDE;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cell_next  = CELL_AW'(idx_sum);
                    state_next = S_CNT_RD;
                end
            end

            S_RCHECK:
            begin
                res_cell_next = CELL_W'(qc_reg);
                res_slot_next = SLOTO_W'(qs_reg);
                if ((32'(qc_reg) >= 32'(MAX_CELLS)) || (PROD_W'(qc_reg) >= mul_reg))
                begin
                    res_stat_next = ST_OUTSIDE;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cell_next  = CELL_AW'(qc_reg);
                    state_next = S_CNT_RD;
                end
            end

            S_CNT_RD:
            begin
                state_next = (op_reg == OP_PLACE) ? S_PLACE : S_READ;
            end

            S_PLACE:
            begin
                res_cell_next = CELL_W'(cell_reg);
                if (32'(cnt_rd_reg) >= 32'(SLOTS_PER_CELL))
                begin
                    res_fill_next = FILL_W'(cnt_rd_reg);
                    res_stat_next = ST_FULL;
                end
                else
                begin
                    bkt_we        = 1'b1;
                    cnt_we        = 1'b1;
                    cnt_waddr     = cell_reg;
                    cnt_wdata     = cnt_inc;
                    res_slot_next = SLOTO_W'(cnt_rd_reg);
                    res_fill_next = FILL_W'(cnt_inc);
                end
                state_next = S_RESULT;
            end

            S_READ:
            begin
                res_fill_next = FILL_W'(cnt_rd_reg);
                if (32'(qs_reg) >= 32'(cnt_rd_reg))
                begin
                    res_stat_next = ST_EMPTY;
                end
                else
                begin
                    res_id_next = bkt_rd_reg;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = res_cell_reg;
                    out_slot_next  = res_slot_reg;
                    out_id_next    = res_id_reg;
                    out_fill_next  = res_fill_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            half_w_reg    <= HALF_WIDTH_RST;
            half_h_reg    <= HALF_HEIGHT_RST;
            edge_reg      <= CELL_EDGE_RST;
            cols_reg      <= GRID_COLUMNS_RST;
            rows_reg      <= GRID_ROWS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            half_w_reg    <= half_w_next;
            half_h_reg    <= half_h_next;
            edge_reg      <= edge_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        qc_reg       <= qc_next;
        qs_reg       <= qs_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        mul_reg      <= mul_next;
        cell_reg     <= cell_next;
        res_cell_reg <= res_cell_next;
        res_slot_reg <= res_slot_next;
        res_id_reg   <= res_id_next;
        res_fill_reg <= res_fill_next;
        res_stat_reg <= res_stat_next;
        out_cell_reg <= out_cell_next;
        out_slot_reg <= out_slot_next;
        out_id_reg   <= out_id_next;
        out_fill_reg <= out_fill_next;
        out_stat_reg <= out_stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cell_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_addr] <= id_reg;
        end
        bkt_rd_reg <= bkt_mem[bkt_addr];
    end

    assign item.ready        = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.cell_index = out_cell_reg;
    assign result.slot_index = out_slot_reg;
    assign result.stored_id  = out_id_reg;
    assign result.cell_fill  = out_fill_reg;
    assign result.status     = out_stat_reg;

endmodule

// ===== rtl/core/sgb_divider.sv =====
// ----------------------------------------------------------------------------
// Spatial grid binner divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgb_divider
    import sgb_pkg::*;
#(
    parameter int DIVIDEND_W = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgb_div_req_t          req,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [EDGE_W-1:0]     rem_reg, rem_next;
    logic [EDGE_W-1:0]     dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [EDGE_W:0]       rem_shift;
    logic [EDGE_W:0]       rem_diff;
    logic                  fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_diff  = rem_shift - {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? rem_diff[EDGE_W-1:0] : rem_shift[EDGE_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/sgb_checker.sv =====
// ----------------------------------------------------------------------------
// Spatial grid binner checker
// Port-level checks on request and result traffic, bound to the core.
// ----------------------------------------------------------------------------
module sgb_checker
    import sgb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [CELL_W-1:0]    cell_index,
    input logic [SLOTO_W-1:0]   slot_index,
    input logic [ID_W-1:0]      stored_id,
    input logic [FILL_W-1:0]    cell_fill,
    input logic [STAT_W-1:0]    status
);

    logic       item_acc;
    logic       result_acc;
    logic [1:0] pending_reg, pending_next;

    assign item_acc   = item_valid && item_ready;
    assign result_acc = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(item_acc) - 2'(result_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result that is offered must stay offered, its status, cell and id unchanged, until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
                                          && $stable(cell_index) && $stable(stored_id))
        else $error("result changed or dropped while stalled");

    // Each request is worked on alone, so ready falls once one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> !item_ready)
        else $error("request taken while another is still in progress");

    // Every result delivered answers a request that was taken earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_acc |-> pending_reg != 2'd0)
        else $error("result delivered with no request outstanding");

    // An outside result carries no id or count; a full cell names no slot or id.
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_OUTSIDE || status == ST_FULL)
        |-> (status == ST_OUTSIDE && stored_id == '0 && cell_fill == '0)
            || (status == ST_FULL && slot_index == '0 && stored_id == '0))
        else $error("result fields inconsistent with status");

endmodule

bind spatial_grid_binner_core sgb_checker u_sgb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cell_index   (result.cell_index),
    .slot_index   (result.slot_index),
    .stored_id    (result.stored_id),
    .cell_fill    (result.cell_fill),
    .status       (result.status)
);
